// File: sv/dsa_pkg.sv
// Shared types and constants for the decimal scale aligner.
// No dependencies; imported by dsa_ctrl, dsa_dp and decimal_scale_aligner_core.
package dsa_pkg;

  localparam int WORD_W  = 32;
  localparam int MANT_W  = 3 * WORD_W;
  localparam int SCALE_W = 5;
  // x*10 < 16*2^96, so four guard bits catch any carry out of the mantissa
  localparam int PROD_W  = MANT_W + 4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture a new item
    logic step;  // one times-ten step on the operand with the smaller scale
  } dsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;  // scales equal or alignment stopped on overflow
  } dsa_stat_t;

endpackage

// File: sv/dsa_ctrl.sv
// Sequencer for the decimal scale aligner: idle, align loop, result strobe.
// Depends on dsa_pkg for the command and status structs.
module dsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  dsa_pkg::dsa_stat_t  stat,
  output dsa_pkg::dsa_cmd_t   cmd,
  output logic                busy,
  output logic                out_valid
);
  import dsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (stat.done) state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands and handshake outputs
  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.step  = (state_r == ST_RUN) && !stat.done;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule

// File: sv/dsa_dp.sv
// Datapath for the decimal scale aligner: operand registers and a shared
// times-ten unit with carry-out check. Depends on dsa_pkg.
module dsa_dp (
  input  logic                          clk,
  input  dsa_pkg::dsa_cmd_t             cmd,
  input  logic [dsa_pkg::MANT_W-1:0]    in_a,
  input  logic [dsa_pkg::SCALE_W-1:0]   in_a_scale,
  input  logic [dsa_pkg::MANT_W-1:0]    in_b,
  input  logic [dsa_pkg::SCALE_W-1:0]   in_b_scale,
  output dsa_pkg::dsa_stat_t            stat,
  output logic [dsa_pkg::MANT_W-1:0]    a_mant,
  output logic [dsa_pkg::SCALE_W-1:0]   a_scale,
  output logic [dsa_pkg::MANT_W-1:0]    b_mant,
  output logic [dsa_pkg::SCALE_W-1:0]   b_scale,
  output logic                          ovf
);
  import dsa_pkg::*;

  logic [MANT_W-1:0]  a_r, b_r;
  logic [SCALE_W-1:0] sa_r, sb_r;
  logic               ovf_r;

  logic               pick_a;
  logic [MANT_W-1:0]  opnd;
  logic [PROD_W-1:0]  prod;
  logic               carry;

  // Shared times-ten: x*8 + x*2
  assign pick_a = (sa_r < sb_r);
  assign opnd   = pick_a ? a_r : b_r;
  assign prod   = {1'b0, opnd, 3'b000} + {3'b000, opnd, 1'b0};
  assign carry  = |prod[PROD_W-1:MANT_W];

  // Operand registers; a step that would carry out leaves them untouched
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= in_a;
      b_r   <= in_b;
      sa_r  <= in_a_scale;
      sb_r  <= in_b_scale;
      ovf_r <= 1'b0;
    end else if (cmd.step) begin
      if (carry) begin
        ovf_r <= 1'b1;
      end else if (pick_a) begin
        a_r  <= prod[MANT_W-1:0];
        sa_r <= sa_r + SCALE_W'(1);
      end else begin
        b_r  <= prod[MANT_W-1:0];
        sb_r <= sb_r + SCALE_W'(1);
      end
    end
  end

  assign stat.done = (sa_r == sb_r) || ovf_r;
  assign a_mant    = a_r;
  assign a_scale   = sa_r;
  assign b_mant    = b_r;
  assign b_scale   = sb_r;
  assign ovf       = ovf_r;

endmodule

// File: sv/decimal_scale_aligner_core.sv
// Decimal scale aligner top level: command-style ports around dsa_ctrl and dsa_dp.
// Depends on dsa_pkg, dsa_ctrl and dsa_dp.
//
// Usage: raise start with both operands while busy is low; the item is taken at
// that edge and busy stays high until the result has been shown. The result
// appears for exactly one cycle with out_valid high and cannot be held off, so
// the receiver must capture it then. One times-ten step is done per cycle by a
// single shared 96-bit multiply-by-ten adder, so an item occupies the block until
// its scales match, or until alignment stops early on overflow; start is taken
// again in the cycle after the strobe.
module decimal_scale_aligner_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [dsa_pkg::WORD_W-1:0]     in_a_word_low,
  input  logic [dsa_pkg::WORD_W-1:0]     in_a_word_mid,
  input  logic [dsa_pkg::WORD_W-1:0]     in_a_word_high,
  input  logic [dsa_pkg::SCALE_W-1:0]    in_a_scale,
  input  logic [dsa_pkg::WORD_W-1:0]     in_b_word_low,
  input  logic [dsa_pkg::WORD_W-1:0]     in_b_word_mid,
  input  logic [dsa_pkg::WORD_W-1:0]     in_b_word_high,
  input  logic [dsa_pkg::SCALE_W-1:0]    in_b_scale,
  output logic                           out_valid,
  output logic [dsa_pkg::WORD_W-1:0]     out_a_low,
  output logic [dsa_pkg::WORD_W-1:0]     out_a_mid,
  output logic [dsa_pkg::WORD_W-1:0]     out_a_high,
  output logic [dsa_pkg::SCALE_W-1:0]    out_a_scale,
  output logic [dsa_pkg::WORD_W-1:0]     out_b_low,
  output logic [dsa_pkg::WORD_W-1:0]     out_b_mid,
  output logic [dsa_pkg::WORD_W-1:0]     out_b_high,
  output logic [dsa_pkg::SCALE_W-1:0]    out_b_scale,
  output logic                           out_overflow
);
  import dsa_pkg::*;

  dsa_cmd_t           cmd;
  dsa_stat_t          stat;
  logic [MANT_W-1:0]  a_mant, b_mant;

  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dsa_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .in_a       ({in_a_word_high, in_a_word_mid, in_a_word_low}),
    .in_a_scale (in_a_scale),
    .in_b       ({in_b_word_high, in_b_word_mid, in_b_word_low}),
    .in_b_scale (in_b_scale),
    .stat       (stat),
    .a_mant     (a_mant),
    .a_scale    (out_a_scale),
    .b_mant     (b_mant),
    .b_scale    (out_b_scale),
    .ovf        (out_overflow)
  );

  // Split mantissas back into words
  assign out_a_low  = a_mant[WORD_W-1:0];
  assign out_a_mid  = a_mant[2*WORD_W-1:WORD_W];
  assign out_a_high = a_mant[MANT_W-1:2*WORD_W];
  assign out_b_low  = b_mant[WORD_W-1:0];
  assign out_b_mid  = b_mant[2*WORD_W-1:WORD_W];
  assign out_b_high = b_mant[MANT_W-1:2*WORD_W];

  // Overflow is flagged exactly when the scales were left unequal
  a_ovf_iff_unequal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overflow == (out_a_scale != out_b_scale)))
    else $error("overflow flag disagrees with final scales");

  // One strobe per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // An accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Scales only ever rise while aligning
  a_scale_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !out_valid && $past(busy)) |->
      (out_a_scale >= $past(out_a_scale) && out_b_scale >= $past(out_b_scale)))
    else $error("scale decreased during alignment");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for decimal_scale_aligner_core: directed and random operand pairs.
// Depends on dsa_pkg and decimal_scale_aligner_core; holds its own alignment predictor.
module tb_top;
  import dsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam bit [MANT_W-1:0] MANT_ONES = '1;

  // One operand pair as taken by the block
  typedef struct packed {
    bit [MANT_W-1:0]  a_mant;
    bit [SCALE_W-1:0] a_scale;
    bit [MANT_W-1:0]  b_mant;
    bit [SCALE_W-1:0] b_scale;
  } dec_pair_t;

  // Aligned pair plus overflow status
  typedef struct packed {
    bit [MANT_W-1:0]  a_mant;
    bit [SCALE_W-1:0] a_scale;
    bit [MANT_W-1:0]  b_mant;
    bit [SCALE_W-1:0] b_scale;
    bit               ovf;
  } aligned_pair_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [WORD_W-1:0]   in_a_word_low, in_a_word_mid, in_a_word_high;
  logic [SCALE_W-1:0]  in_a_scale;
  logic [WORD_W-1:0]   in_b_word_low, in_b_word_mid, in_b_word_high;
  logic [SCALE_W-1:0]  in_b_scale;
  logic                out_valid;
  logic [WORD_W-1:0]   out_a_low, out_a_mid, out_a_high;
  logic [SCALE_W-1:0]  out_a_scale;
  logic [WORD_W-1:0]   out_b_low, out_b_mid, out_b_high;
  logic [SCALE_W-1:0]  out_b_scale;
  logic                out_overflow;

  aligned_pair_t pending_alignments[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;

  decimal_scale_aligner_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_a_word_low  (in_a_word_low),
    .in_a_word_mid  (in_a_word_mid),
    .in_a_word_high (in_a_word_high),
    .in_a_scale     (in_a_scale),
    .in_b_word_low  (in_b_word_low),
    .in_b_word_mid  (in_b_word_mid),
    .in_b_word_high (in_b_word_high),
    .in_b_scale     (in_b_scale),
    .out_valid      (out_valid),
    .out_a_low      (out_a_low),
    .out_a_mid      (out_a_mid),
    .out_a_high     (out_a_high),
    .out_a_scale    (out_a_scale),
    .out_b_low      (out_b_low),
    .out_b_mid      (out_b_mid),
    .out_b_high     (out_b_high),
    .out_b_scale    (out_b_scale),
    .out_overflow   (out_overflow)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_alignments.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Predictor: times ten on the smaller-scale mantissa until scales match or
  // a step would carry out of 96 bits; that step is dropped.
  function automatic aligned_pair_t align_scales(input dec_pair_t p);
    aligned_pair_t r;
    bit [PROD_W-1:0] prod;
    r.a_mant  = p.a_mant;
    r.a_scale = p.a_scale;
    r.b_mant  = p.b_mant;
    r.b_scale = p.b_scale;
    r.ovf     = 1'b0;
    while (!r.ovf && r.a_scale != r.b_scale) begin
      if (r.a_scale < r.b_scale) begin
        prod = PROD_W'(r.a_mant) * 10;
        if (prod[PROD_W-1:MANT_W] != '0) r.ovf = 1'b1;
        else begin
          r.a_mant  = prod[MANT_W-1:0];
          r.a_scale = r.a_scale + 1'b1;
        end
      end else begin
        prod = PROD_W'(r.b_mant) * 10;
        if (prod[PROD_W-1:MANT_W] != '0) r.ovf = 1'b1;
        else begin
          r.b_mant  = prod[MANT_W-1:0];
          r.b_scale = r.b_scale + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Largest mantissa that survives k times-ten steps
  function automatic bit [MANT_W-1:0] survive_limit(input int unsigned k);
    bit [MANT_W-1:0] p10;
    p10 = 1;
    repeat (k) p10 = p10 * 10;
    return MANT_ONES / p10;
  endfunction

  function automatic bit [MANT_W-1:0] rand_mant();
    bit [MANT_W-1:0] m;
    int unsigned mode;
    m = {$urandom, $urandom, $urandom};
    mode = $urandom_range(0, 9);
    if (mode == 0) m = '0;
    else if (mode >= 4 && mode <= 8) m = m >> $urandom_range(0, MANT_W - 1);
    else if (mode == 9) begin
      // straddle the point where the k-th step overflows
      m = survive_limit($urandom_range(1, 28));
      m = m - 1 + $urandom_range(0, 2);
    end
    return m;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 45);
  endfunction

  function automatic dec_pair_t make_pair(input bit [MANT_W-1:0] am, input int unsigned as,
                                          input bit [MANT_W-1:0] bm, input int unsigned bs);
    dec_pair_t p;
    p.a_mant  = am;
    p.a_scale = SCALE_W'(as);
    p.b_mant  = bm;
    p.b_scale = SCALE_W'(bs);
    return p;
  endfunction

  // Present one item, hold it until taken, then optionally drop start for a gap
  task automatic send_pair(input dec_pair_t p, input int unsigned gap);
    start          <= 1'b1;
    in_a_word_low  <= p.a_mant[31:0];
    in_a_word_mid  <= p.a_mant[63:32];
    in_a_word_high <= p.a_mant[95:64];
    in_a_scale     <= p.a_scale;
    in_b_word_low  <= p.b_mant[31:0];
    in_b_word_mid  <= p.b_mant[63:32];
    in_b_word_high <= p.b_mant[95:64];
    in_b_scale     <= p.b_scale;
    do @(posedge clk); while (busy !== 1'b0);
    pending_alignments.push_back(align_scales(p));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_alignments.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_equal_scales();
    send_pair(make_pair(MANT_ONES, 0, MANT_ONES, 0), 0);
    send_pair(make_pair(MANT_ONES, 31, '0, 31), 1);
    send_pair(make_pair(rand_mant(), 14, rand_mant(), 14), 0);
    send_pair(make_pair('0, 28, MANT_ONES, 28), 2);
  endtask

  task automatic test_zero_mantissa();
    send_pair(make_pair('0, 0, MANT_ONES, 31), 0);
    send_pair(make_pair(MANT_ONES, 31, '0, 0), 0);
    send_pair(make_pair('0, 5, '0, 20), 3);
  endtask

  task automatic test_overflow_edges();
    // one step fits exactly, one more count does not
    send_pair(make_pair(survive_limit(1), 3, 96'd7, 4), 0);
    send_pair(make_pair(survive_limit(1) + 1, 3, 96'd7, 4), 0);
    // full mantissa cannot take even one step
    send_pair(make_pair(96'd12345, 28, MANT_ONES, 0), 1);
    // b survives two of its five steps and overflows on the third
    send_pair(make_pair(96'd1, 20, survive_limit(2), 15), 0);
    // 10^28 fits, 10^29 does not
    send_pair(make_pair(96'd1, 0, 96'd1, 31), 0);
    send_pair(make_pair(96'd1, 0, 96'd9, 28), 4);
    send_pair(make_pair(96'd9, 30, 96'd8, 1), 0);
  endtask

  task automatic test_extreme_scales();
    send_pair(make_pair(96'd3, 31, 96'd5, 29), 0);
    send_pair(make_pair(96'd42, 0, 96'd17, 31), 0);
    send_pair(make_pair(MANT_ONES, 31, MANT_ONES, 30), 1);
    send_pair(make_pair(96'd1, 31, 96'd1, 0), 0);
    wait_drained();
  endtask

  task automatic test_random();
    dec_pair_t p;
    bit burst;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      p.a_mant  = rand_mant();
      p.b_mant  = rand_mant();
      p.a_scale = SCALE_W'($urandom_range(0, 31));
      // near scales exercise short alignments, the rest spread over all pairs
      if ($urandom_range(0, 1) == 1)
        p.b_scale = p.a_scale + SCALE_W'($urandom_range(0, 6)) - SCALE_W'(3);
      else
        p.b_scale = SCALE_W'($urandom_range(0, 31));
      burst = ((i / 60) % 3) == 2;
      send_pair(p, burst ? 0 : pick_gap());
      if (i % 250 == 249) wait_drained();
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Result check: every strobe is compared with the oldest expectation
  always @(posedge clk) begin : result_check
    aligned_pair_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_alignments.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no item outstanding", $realtime);
      end else begin
        want = pending_alignments.pop_front();
        check_field("out_a_low",    want.a_mant[31:0],  out_a_low);
        check_field("out_a_mid",    want.a_mant[63:32], out_a_mid);
        check_field("out_a_high",   want.a_mant[95:64], out_a_high);
        check_field("out_a_scale",  want.a_scale,       out_a_scale);
        check_field("out_b_low",    want.b_mant[31:0],  out_b_low);
        check_field("out_b_mid",    want.b_mant[63:32], out_b_mid);
        check_field("out_b_high",   want.b_mant[95:64], out_b_high);
        check_field("out_b_scale",  want.b_scale,       out_b_scale);
        check_field("out_overflow", want.ovf,           out_overflow);
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_a_word_low  <= '0;
    in_a_word_mid  <= '0;
    in_a_word_high <= '0;
    in_a_scale     <= '0;
    in_b_word_low  <= '0;
    in_b_word_mid  <= '0;
    in_b_word_high <= '0;
    in_b_scale     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_equal_scales();
    test_zero_mantissa();
    test_overflow_edges();
    test_extreme_scales();
    test_random();

    // drain, then watch for stray strobes
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += pending_alignments.size();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
